// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks for the rtl top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/hvn_pkg.sv -----
// ----------------------------------------------------------------------------
// hvn_pkg
// constants and helper functions for the hashed value noise pipeline
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int COORD_W       = 26;
    localparam int S_TDATA_W     = 56;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROW_SHIFT     = 20;

    localparam int HASH_SH1 = 17;
    localparam int HASH_SH2 = 11;
    localparam int HASH_SH3 = 15;
    localparam int HASH_SH4 = 14;

    localparam logic [31:0] ROW_1D     = 32'd1024;
    localparam logic [31:0] SEED_RESET = 32'hDEADBEF0;
    localparam logic [31:0] HASH_C1    = 32'hED5AD4BB;
    localparam logic [31:0] HASH_C2    = 32'hAC4C1B51;
    localparam logic [31:0] HASH_C3    = 32'h31848BAB;
    localparam logic [17:0] HASH_MOD   = 18'd65537;

    // ix + 1048577*iy + offset, modulo 2^32
    function automatic logic [31:0] row_seed(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] off);
        return px + py + (py << ROW_SHIFT) + off;
    endfunction

    // v mod 65537 using 2^16 = -1
    function automatic logic [16:0] hash_mod(input logic [31:0] v);
        logic [17:0] d;
        d = {2'b00, v[15:0]} - {2'b00, v[31:16]};
        if (d[17]) begin
            d = d + HASH_MOD;
        end
        return d[16:0];
    endfunction

endpackage

// ----- src/hashed_value_noise_1d_2d_top.sv -----
// ----------------------------------------------------------------------------
// hashed_value_noise_1d_2d_top
// 1d and skewed 2d value noise over a hashed integer lattice
// pipeline: 8 register stages, from the stage 1 registers through seed, hash and lattice to the lerp and result
// throughput: one item per cycle while no stall holds the pipeline, with three pipelined hash multipliers per lane
// stall: the whole pipeline holds while a result waits on m_tready
// reset: synchronous active-low aresetn clears all valid bits and loads the seed offset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_value_noise_1d_2d_top #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,    // hash_seed_offset

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hvn_pkg::S_TDATA_W-1:0]       s_tdata,     // x_coord, y_coord
    input  logic                                s_tuser,     // mode

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((FRAC_BITS+8)/8)*8-1:0]      m_tdata      // noise_value
);

    localparam int F           = FRAC_BITS;
    localparam int CW          = hvn_pkg::COORD_W;
    localparam int SX_W        = F + 32;
    localparam int NSTG        = 8;
    localparam int OUT_TDATA_W = ((F + 8) / 8) * 8;

    localparam logic [F:0]   ONE_FX = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0] TWO_FX = {2'b10, {F{1'b0}}};

    typedef struct packed {
        logic       mode;
        logic [F:0] w1;
        logic [F:0] w2;
    } side_t;

    logic en;
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [31:0] seed_off_reg;

    // stage 1
    logic            mode1_reg;
    logic [31:0]     ix1_reg, iy1_reg, ix1_next, iy1_next;
    logic [F-1:0]    dx1_reg, dy1_reg, dx1_next;
    logic [CW-1:0]   x_in, y_in;
    logic [28:0]     y5;
    logic [SX_W-1:0] sx;

    // stage 2
    logic [31:0]  ixp, iyp;
    logic [F+1:0] dxy, s_sum;
    logic         upper;
    logic [31:0]  px [3], py [3];
    side_t        side_next;
    logic [31:0]  seed_reg [3], seed_next [3];
    side_t        side_reg [5];

    // hash stages
    logic [31:0] h3_reg [3], h4_reg [3], h5_reg [3];
    logic [31:0] h3_next [3], h4_next [3], h5_next [3];
    logic [31:0] v6 [3];
    logic [F+16:0] lat_wide [3];
    logic [F:0]  lat_reg [3], lat_next [3];

    // lerp stages
    logic signed [F+1:0]   d7, d8;
    logic signed [2*F+3:0] p7, p8, t7w, t8w;
    logic [F:0]  t_reg, c_reg, w2_7_reg, t_next;
    logic        mode7_reg;
    logic [F:0]  res_reg, res_next;

    assign en        = !vld_reg[NSTG-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NSTG-1];
    assign m_tdata   = OUT_TDATA_W'(res_reg);

    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid};

    // stage 1: skew and split
    always_comb begin
        x_in = s_tdata[CW-1:0];
        y_in = s_tdata[2*CW-1:CW];
        y5   = {3'b000, y_in} + {1'b0, y_in, 2'b00};
        sx   = SX_W'(x_in) + (SX_W'(hvn_pkg::ROW_1D) << F) - SX_W'(y5[28:3]);
        if (s_tuser) begin
            ix1_next = sx[F+31:F];
            dx1_next = sx[F-1:0];
        end else begin
            ix1_next = 32'(x_in[CW-1:F]);
            dx1_next = x_in[F-1:0];
        end
        iy1_next = 32'(y_in[CW-1:F]);
    end

    // stage 2: lattice points, seeds and weights
    always_comb begin
        ixp   = ix1_reg + 32'd1;
        iyp   = iy1_reg + 32'd1;
        dxy   = (F+2)'(dx1_reg) + (F+2)'(dy1_reg);
        upper = dxy > (F+2)'(ONE_FX);
        s_sum = (F+2)'(dx1_reg) + (F+2)'(ONE_FX) - (F+2)'(dy1_reg);

        px[0] = ix1_reg;
        py[0] = mode1_reg ? iyp : hvn_pkg::ROW_1D;
        px[1] = ixp;
        py[1] = mode1_reg ? iy1_reg : hvn_pkg::ROW_1D;
        px[2] = upper ? ixp : ix1_reg;
        py[2] = upper ? iyp : iy1_reg;

        side_next.mode = mode1_reg;
        side_next.w1   = mode1_reg ? s_sum[F+1:1] : (F+1)'(dx1_reg);
        if (upper) begin
            side_next.w2 = (F+1)'(TWO_FX - dxy);
        end else begin
            side_next.w2 = dxy[F:0];
        end
    end

    // hash lanes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            seed_next[k] = hvn_pkg::row_seed(px[k], py[k], seed_off_reg);
            h3_next[k]   = (seed_reg[k] ^ (seed_reg[k] >> hvn_pkg::HASH_SH1)) * hvn_pkg::HASH_C1;
            h4_next[k]   = (h3_reg[k] ^ (h3_reg[k] >> hvn_pkg::HASH_SH2)) * hvn_pkg::HASH_C2;
            h5_next[k]   = (h4_reg[k] ^ (h4_reg[k] >> hvn_pkg::HASH_SH3)) * hvn_pkg::HASH_C3;
            v6[k]        = h5_reg[k] ^ (h5_reg[k] >> hvn_pkg::HASH_SH4);
            lat_wide[k]  = {hvn_pkg::hash_mod(v6[k]), {F{1'b0}}};
            lat_next[k]  = lat_wide[k][F+16:16];
        end
    end

    // stage 7: lerp along the first edge
    always_comb begin
        d7     = $signed({1'b0, lat_reg[1]}) - $signed({1'b0, lat_reg[0]});
        p7     = d7 * $signed({1'b0, side_reg[4].w1});
        t7w    = $signed((2*F+4)'(lat_reg[0])) + (p7 >>> F);
        t_next = t7w[F:0];
    end

    // stage 8: lerp toward the triangle corner in 2d mode; 1d mode passes the first lerp through
    always_comb begin
        d8  = $signed({1'b0, t_reg}) - $signed({1'b0, c_reg});
        p8  = d8 * $signed({1'b0, w2_7_reg});
        t8w = $signed((2*F+4)'(c_reg)) + (p8 >>> F);
        res_next = mode7_reg ? t8w[F:0] : t_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            seed_off_reg <= hvn_pkg::SEED_RESET;
        end else begin
            if (en) begin
                vld_reg <= vld_next;
            end
            if (cfg_valid && cfg_ready) begin
                seed_off_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= s_tuser;
            ix1_reg   <= ix1_next;
            iy1_reg   <= iy1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= y_in[F-1:0];

            side_reg[0] <= side_next;
            for (int i = 1; i < 5; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                seed_reg[k] <= seed_next[k];
                h3_reg[k]   <= h3_next[k];
                h4_reg[k]   <= h4_next[k];
                h5_reg[k]   <= h5_next[k];
                lat_reg[k]  <= lat_next[k];
            end

            t_reg     <= t_next;
            c_reg     <= lat_reg[2];
            w2_7_reg  <= side_reg[4].w2;
            mode7_reg <= side_reg[4].mode;
            res_reg   <= res_next;
        end
    end

    `ASSERT_CLK(a_accept_enters, (s_tvalid && s_tready) |=> vld_reg[0], "accepted item not in stage 1")
    `ASSERT_CLK(a_stall_freezes, (m_tvalid && !m_tready) |=> $stable(vld_reg), "pipeline moved during stall")
    `ASSERT_CLK(a_noise_range, m_tvalid |-> (res_reg <= ONE_FX), "noise value above one")
    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (vld_reg == '0), "valid bits not cleared by reset")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hashed value noise block: coordinate items in
// both modes go in over the input stream under random idling on both sides,
// each accepted item is scored against a bit-exact noise predictor, and the
// seed offset is rewritten between phases while the pipeline is empty
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_W  = hvn_pkg::COORD_W;
    localparam int S_W      = hvn_pkg::S_TDATA_W;
    localparam int PAD_W    = S_W - 2 * COORD_W;
    localparam int M_W      = ((hvn_pkg::FRAC_BITS_DEF + 8) / 8) * 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PAD_W-1:0]   pad;
    } coord_item_t;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [16:0]        noise;
    } noise_exp_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [31:0]    cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;    // x_coord, y_coord
    logic           s_tuser = 1'b0;  // mode
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;         // noise_value

    coord_item_t coord_q[$];
    noise_exp_t  noise_exp_q[$];
    coord_item_t drv_item;
    noise_exp_t  got_exp;
    logic [31:0] seed_off;
    logic        idle_en = 1'b1;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          stall_cnt = 0;
    int          n_errors = 0;

    hashed_value_noise_1d_2d_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // noise predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] triple32_mix(input logic [31:0] v);
        v = v ^ (v >> hvn_pkg::HASH_SH1);
        v = v * hvn_pkg::HASH_C1;
        v = v ^ (v >> hvn_pkg::HASH_SH2);
        v = v * hvn_pkg::HASH_C2;
        v = v ^ (v >> hvn_pkg::HASH_SH3);
        v = v * hvn_pkg::HASH_C3;
        v = v ^ (v >> hvn_pkg::HASH_SH4);
        return v;
    endfunction

    function automatic logic [16:0] lattice_noise(input logic [31:0] ix, input logic [31:0] iy);
        logic [31:0] s;
        s = ix + 32'd1048577 * iy + seed_off;
        return 17'(triple32_mix(s) % 32'd65537);
    endfunction

    // clamped lerp, weight in q1.16
    function automatic logic [16:0] lerp_q16(input logic [16:0] a, input logic [16:0] b,
                                             input logic [17:0] w);
        logic [63:0] acc;
        if (w > 18'd65536) begin
            return b;
        end
        acc = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
        return 17'(acc >> 16);
    endfunction

    function automatic logic [16:0] predict_noise(input logic mode, input logic [25:0] x,
                                                  input logic [25:0] y);
        logic [31:0] sx;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [17:0] dx;
        logic [17:0] dy;
        logic [17:0] wt;
        logic [16:0] t;
        if (mode == 1'b0) begin
            ix = 32'(x[25:16]);
            return lerp_q16(lattice_noise(ix, hvn_pkg::ROW_1D),
                            lattice_noise(ix + 32'd1, hvn_pkg::ROW_1D), 18'(x[15:0]));
        end
        sx = 32'(x) + (32'd1024 << 16) - ((32'(y) * 32'd5) >> 3);
        ix = 32'(sx[31:16]);
        iy = 32'(y[25:16]);
        dx = 18'(sx[15:0]);
        dy = 18'(y[15:0]);
        wt = (dx + 18'd65536 - dy) >> 1;
        t  = lerp_q16(lattice_noise(ix, iy + 32'd1), lattice_noise(ix + 32'd1, iy), wt);
        if (dx + dy > 18'd65536) begin
            return lerp_q16(lattice_noise(ix + 32'd1, iy + 32'd1), t,
                            18'd131072 - dx - dy);
        end
        return lerp_q16(lattice_noise(ix, iy), t, dx + dy);
    endfunction

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                noise_exp_q.push_back('{s_tuser, s_tdata[25:0], s_tdata[51:26],
                                       predict_noise(s_tuser, s_tdata[25:0],
                                                     s_tdata[51:26])});
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 7) == 0) begin
                    src_gap  <= $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (coord_q.size() != 0) begin
                    drv_item = coord_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_item.pad, drv_item.y, drv_item.x};
                    s_tuser  <= drv_item.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (noise_exp_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none actual %h", $time,
                             m_tdata[16:0]);
                    n_errors++;
                end else begin
                    got_exp = noise_exp_q.pop_front();
                    if (m_tdata[16:0] !== got_exp.noise) begin
                        $display("%0t: noise mismatch mode=%0d x=%h y=%h expected %h actual %h",
                                 $time, got_exp.mode, got_exp.x, got_exp.y, got_exp.noise,
                                 m_tdata[16:0]);
                        n_errors++;
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap  <= snk_gap - 1;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                snk_gap  <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // no progress watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d items outstanding", $time, noise_exp_q.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic mode, input logic [25:0] x, input logic [25:0] y,
                             input logic [PAD_W-1:0] pad);
        coord_q.push_back('{mode, x, y, pad});
    endtask

    // x such that the skewed fraction plus the y fraction lands on one plus delta
    function automatic logic [25:0] diag_x(input logic [25:0] y, input int delta);
        int dx_t;
        int q;
        dx_t = (65536 - int'(y[15:0]) + delta) & 16'hFFFF;
        q    = int'((32'(y) * 32'd5) >> 3);
        return {10'($urandom), 16'((dx_t + q) & 16'hFFFF)};
    endfunction

    function automatic logic [25:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return {10'($urandom), 16'h0000};
            3: return {10'($urandom), 16'hFFFF};
            4: return {($urandom_range(0, 1) ? 10'h3FF : 10'h000), 16'($urandom)};
            default: return 26'($urandom);
        endcase
    endfunction

    task automatic random_items(input int n);
        logic        mode;
        logic [25:0] x;
        logic [25:0] y;
        logic [3:0]  pad;
        repeat (n) begin
            mode = 1'($urandom_range(0, 1));
            y    = pick_coord();
            x    = pick_coord();
            if (mode && $urandom_range(0, 3) == 0) begin
                x = diag_x(y, $urandom_range(0, 2) - 1);
            end
            pad  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0;
            push_item(mode, x, y, pad);
        end
    endtask

    task automatic wait_drain();
        do begin
            @(negedge aclk);
        end while (coord_q.size() != 0 || s_tvalid || noise_exp_q.size() != 0);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_off = v;
        @(negedge aclk);
    endtask

    initial begin
        seed_off = hvn_pkg::SEED_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 1d corners, y must not matter
        push_item(1'b0, 26'h0, 26'h0, 4'h0);
        push_item(1'b0, '1, 26'h0, 4'h0);
        push_item(1'b0, {10'd5, 16'h0000}, '1, 4'h0);
        push_item(1'b0, {10'd5, 16'hFFFF}, 26'h155_5555, 4'h0);
        push_item(1'b0, {10'h3FF, 16'h8000}, 26'h0, 4'h0);
        push_item(1'b0, {10'h200, 16'h0001}, 26'h0, 4'hF);
        // 2d corners
        push_item(1'b1, 26'h0, 26'h0, 4'h0);
        push_item(1'b1, '1, '1, 4'h0);
        push_item(1'b1, 26'h0, '1, 4'h0);
        push_item(1'b1, '1, 26'h0, 4'h0);
        push_item(1'b1, {10'd512, 16'h0}, {10'd0, 16'hFFFF}, 4'h0);
        push_item(1'b1, {10'd1, 16'hFFFF}, {10'd8, 16'h0}, 4'h0);
        push_item(1'b1, 26'h2AA_AAAA, 26'h155_5555, 4'hF);
        // triangle boundary: fractions summing to just under, at and over one
        push_item(1'b1, diag_x(26'h012_3456, -1), 26'h012_3456, 4'h0);
        push_item(1'b1, diag_x(26'h012_3456, 0), 26'h012_3456, 4'h0);
        push_item(1'b1, diag_x(26'h012_3456, 1), 26'h012_3456, 4'h0);
        push_item(1'b1, diag_x('1, 0), '1, 4'h0);
        push_item(1'b1, diag_x(26'h3F0_0001, 0), 26'h3F0_0001, 4'h0);
        random_items(250);
        wait_drain();

        write_seed(32'h0000_0000);
        random_items(250);
        wait_drain();

        write_seed(32'hFFFF_FFFF);
        random_items(250);
        wait_drain();

        write_seed($urandom);
        random_items(250);
        wait_drain();

        idle_en = 1'b0;
        write_seed($urandom);
        random_items(200);
        wait_drain();

        repeat (20) @(posedge aclk);
        if (n_errors == 0 && noise_exp_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
